### rtl/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    // Number of cells in the cache
    localparam int ENTRIES = 16;
    // Cell index and age rank width
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Fill count width, holds 0..ENTRIES
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // Operation kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Write request into the key/value store
    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        addr;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } ram_wr_t;

endpackage

`default_nettype wire

### rtl/lru_key_value_cache.sv
// A get first runs the key scan, which walks the cells one per cycle through a
// single compare unit and stops at the first hit; a hit passes through ST_TOUCH
// to update the ranks, and the result word in ST_RESP waits on m_tready.
// A put holds the block through the scan and the update or insert and returns no word.
// Only one item is in flight: the next word is accepted only after an item
// completes, and s_tready is high only between items.
// Reset (rst_n low, asynchronous): all cells invalid, ranks and count zero, capacity 16.
`default_nettype none

module lru_key_value_cache (
    input  wire                         clk,
    input  wire                         rst_n,
    // Configuration: capacity register
    input  wire                         cfg_we,
    input  wire  [lkvc_pkg::CAP_W-1:0]  cfg_data,
    // Input stream
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [63:0]                 s_tdata,   // [31:0] key, [63:32] value
    input  wire                         s_tuser,   // kind
    // Result stream
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] read_value
    output logic                        m_tuser    // hit
);
    import lkvc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_TOUCH  = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    // Control state
    logic [2:0]             state_reg, state_next;
    logic [CAP_W-1:0]       capacity_reg;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]       rank_reg [ENTRIES];
    logic [IDX_W-1:0]       rank_next [ENTRIES];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   issue_on_reg, issue_on_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   best_found_reg, best_found_next;
    logic                   free_found_reg, free_found_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload state
    logic                   kind_reg, kind_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]       best_rank_reg, best_rank_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                   resp_hit_reg, resp_hit_next;
    logic signed [VAL_W-1:0] resp_val_reg, resp_val_next;
    logic                   out_hit_reg, out_hit_next;
    logic [VAL_W-1:0]       out_val_reg, out_val_next;

    // Store interface
    ram_wr_t                ram_wr;
    logic                   ram_rd_en;
    logic signed [KEY_W-1:0] ram_rd_key;
    logic signed [VAL_W-1:0] ram_rd_value;

    // Insert decision
    logic [CNT_W-1:0]       cap_sat;
    logic                   evict;
    logic                   insert_ok;
    logic [IDX_W-1:0]       slot;
    logic                   key_match;

    lkvc_ram u_ram (
        .clk      (clk),
        .wr       (ram_wr),
        .rd_en    (ram_rd_en),
        .rd_addr  (issue_idx_reg),
        .rd_key   (ram_rd_key),
        .rd_value (ram_rd_value)
    );

    // Capacity saturates at the cell count
    always_comb
    begin
        if (int'(capacity_reg) > ENTRIES)
            cap_sat = CNT_W'(ENTRIES);
        else
            cap_sat = CNT_W'(capacity_reg);
    end

    assign evict     = (count_reg >= cap_sat) && best_found_reg;
    assign insert_ok = (cap_sat != '0) && (evict || free_found_reg);
    assign slot      = evict ? best_idx_reg : free_idx_reg;
    assign key_match = valid_reg[cmp_idx_reg] && (ram_rd_key == key_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        count_next      = count_reg;
        issue_on_next   = issue_on_reg;
        cmp_valid_next  = cmp_valid_reg;
        best_found_next = best_found_reg;
        free_found_next = free_found_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_rank_next  = best_rank_reg;
        free_idx_next   = free_idx_reg;
        hit_idx_next    = hit_idx_reg;
        resp_hit_next   = resp_hit_reg;
        resp_val_next   = resp_val_reg;
        out_hit_next    = out_hit_reg;
        out_val_next    = out_val_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ram_rd_en       = 1'b0;
        ram_wr.we       = 1'b0;
        ram_wr.addr     = hit_idx_reg;
        ram_wr.key      = key_reg;
        ram_wr.value    = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next       = s_tuser;
                    key_next        = s_tdata[31:0];
                    val_next        = s_tdata[63:32];
                    issue_idx_next  = '0;
                    issue_on_next   = 1'b1;
                    cmp_valid_next  = 1'b0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one cell read per cycle
                cmp_valid_next = issue_on_reg;
                cmp_idx_next   = issue_idx_reg;
                if (issue_on_reg)
                begin
                    ram_rd_en = 1'b1;
                    if (issue_idx_reg == IDX_W'(ENTRIES - 1))
                        issue_on_next = 1'b0;
                    else
                        issue_idx_next = issue_idx_reg + 1'b1;
                end
                // Compare the cell read last cycle
                if (cmp_valid_reg)
                begin
                    if (key_match)
                    begin
                        hit_idx_next   = cmp_idx_reg;
                        resp_val_next  = ram_rd_value;
                        issue_on_next  = 1'b0;
                        cmp_valid_next = 1'b0;
                        state_next     = ST_TOUCH;
                    end
                    else
                    begin
                        if (valid_reg[cmp_idx_reg] &&
                            (!best_found_reg || rank_reg[cmp_idx_reg] > best_rank_reg))
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = cmp_idx_reg;
                            best_rank_next  = rank_reg[cmp_idx_reg];
                        end
                        if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                        begin
                            cmp_valid_next = 1'b0;
                            if (kind_reg == KIND_PUT)
                                state_next = ST_INSERT;
                            else
                            begin
                                resp_hit_next = 1'b0;
                                resp_val_next = MISS_VALUE;
                                state_next    = ST_RESP;
                            end
                        end
                    end
                end
            end

            ST_TOUCH:
            begin
                // Younger cells age by one, hit cell becomes most recent
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < rank_reg[hit_idx_reg]))
                        rank_next[i] = rank_reg[i] + 1'b1;
                end
                rank_next[hit_idx_reg] = '0;
                if (kind_reg == KIND_PUT)
                begin
                    ram_wr.we  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    resp_hit_next = 1'b1;
                    state_next    = ST_RESP;
                end
            end

            ST_INSERT:
            begin
                // Evict the oldest or fill the lowest free cell; nothing is stored at capacity zero
                if (insert_ok)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i] && !(evict && (IDX_W'(i) == slot)))
                            rank_next[i] = rank_reg[i] + 1'b1;
                    end
                    rank_next[slot]  = '0;
                    valid_next[slot] = 1'b1;
                    if (!evict)
                        count_next = count_reg + 1'b1;
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = slot;
                end
                state_next = ST_IDLE;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = resp_hit_reg;
                    out_val_next   = resp_val_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            issue_on_reg   <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                capacity_reg <= cfg_data;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            issue_on_reg   <= issue_on_next;
            cmp_valid_reg  <= cmp_valid_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            rank_reg       <= rank_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_rank_reg <= best_rank_next;
        free_idx_reg  <= free_idx_next;
        hit_idx_reg   <= hit_idx_next;
        resp_hit_reg  <= resp_hit_next;
        resp_val_reg  <= resp_val_next;
        out_hit_reg   <= out_hit_next;
        out_val_reg   <= out_val_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_val_reg;

endmodule

`default_nettype wire

### rtl/lkvc_ram.sv
// Key and value storage for the cache cells, one write and one read port.
`default_nettype none

module lkvc_ram (
    input  wire                            clk,
    input  lkvc_pkg::ram_wr_t              wr,
    input  wire                            rd_en,
    input  wire  [lkvc_pkg::IDX_W-1:0]     rd_addr,
    output logic signed [lkvc_pkg::KEY_W-1:0] rd_key,
    output logic signed [lkvc_pkg::VAL_W-1:0] rd_value
);
    import lkvc_pkg::*;

    logic [KEY_W-1:0] key_mem   [ENTRIES];
    logic [VAL_W-1:0] value_mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            key_mem[wr.addr]   <= wr.key;
            value_mem[wr.addr] <= wr.value;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= value_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/lkvc_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
`default_nettype none

module lkvc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tuser
);
    import lkvc_pkg::*;

    // One item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // The key scan takes cycles: no result appears right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result too early after accept");

    // A miss always reads back all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == MISS_VALUE))
        else $error("miss word without miss value");

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
